// ===== hw/rtl/tcw_pkg.sv =====
// shared types and constants for the text console char writer
package tcw_pkg;

    localparam int DEF_COLS     = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STOP = 8;

    localparam int CHAR_W   = 8;
    localparam int CELL_W   = 16;
    localparam int POS_W    = 11;
    localparam int ROW_IN_W = 5;
    localparam int COL_IN_W = 7;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL_MOVE,
        ST_SCROLL_BLANK,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_cmd_t;

endpackage

// ===== hw/rtl/tcw_cell_ram.sv =====
// character cell store: one write port, one registered read port
module tcw_cell_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  tcw_pkg::mem_cmd_t         cmd,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [tcw_pkg::CELL_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// sequencer: cursor, op decode, scroll/clear/init sweeps over the cell store
module tcw_ctrl #(
    parameter int COLS     = tcw_pkg::DEF_COLS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP,
    parameter int ADDR_W   = $clog2(ROWS * COLS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcw_pkg::ROW_IN_W-1:0] row,
    input  logic [tcw_pkg::COL_IN_W-1:0] column,
    input  logic [tcw_pkg::CHAR_W-1:0]   color,
    input  logic                         res_ready,
    output logic                         res_valid,
    output logic [tcw_pkg::POS_W-1:0]    res_pos,
    output logic [tcw_pkg::CHAR_W-1:0]   res_char,
    output logic [tcw_pkg::CHAR_W-1:0]   res_color,
    output tcw_pkg::mem_cmd_t            mem_cmd,
    output logic [ADDR_W-1:0]            mem_waddr,
    output logic [tcw_pkg::CELL_W-1:0]   mem_wdata,
    output logic [ADDR_W-1:0]            mem_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]   mem_rdata
);

    localparam int CELLS      = ROWS * COLS;
    localparam int MOVE_CELLS = (ROWS - 1) * COLS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLS);

    tcw_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0]         cnt_reg, cnt_next;
    logic                      phase_reg, phase_next;
    logic [ROW_W-1:0]          crow_reg, crow_next;
    logic [COL_W-1:0]          ccol_reg, ccol_next;
    logic                      rd_ok_reg, rd_ok_next;
    logic [tcw_pkg::CHAR_W-1:0] rchar_reg, rchar_next;
    logic [tcw_pkg::CHAR_W-1:0] rcolor_reg, rcolor_next;

    logic              accept;
    logic              in_range;
    logic              last_row;
    logic              last_col;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] in_addr;

    // next tab stop per column, and whether it runs off the line
    logic [COL_W-1:0] tab_col [COLS];
    logic             tab_wrap [COLS];

    for (genvar g = 0; g < COLS; g++)
    begin : g_tab
        localparam int TabT = ((g / TAB_STOP) + 1) * TAB_STOP;
        assign tab_col[g]  = (TabT >= COLS) ? '0 : COL_W'(TabT);
        assign tab_wrap[g] = (TabT >= COLS);
    end

    assign accept   = in_valid && (state_reg == tcw_pkg::ST_IDLE);
    assign in_range = (int'(row) < ROWS) && (int'(column) < COLS);
    assign last_row = (crow_reg == ROW_W'(ROWS - 1));
    assign last_col = (ccol_reg == COL_W'(COLS - 1));
    assign cur_addr = ADDR_W'(crow_reg) * ADDR_W'(COLS) + ADDR_W'(ccol_reg);
    assign in_addr  = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(column);

    // next state and register updates
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        crow_next   = crow_reg;
        ccol_next   = ccol_reg;
        rd_ok_next  = rd_ok_reg;
        rchar_next  = rchar_reg;
        rcolor_next = rcolor_reg;
        unique case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    rchar_next  = '0;
                    rcolor_next = '0;
                    cnt_next    = '0;
                    phase_next  = 1'b0;
                    state_next  = tcw_pkg::ST_DONE;
                    unique case (tcw_pkg::op_t'(op))
                        tcw_pkg::OP_PUT:
                        begin
                            // row advance, scroll when on the last row
                            logic adv;
                            adv = 1'b0;
                            case (char_code)
                                tcw_pkg::CH_NUL:
                                begin
                                end
                                tcw_pkg::CH_NL:
                                begin
                                    ccol_next = '0;
                                    adv       = 1'b1;
                                end
                                tcw_pkg::CH_CR:
                                begin
                                    ccol_next = '0;
                                end
                                tcw_pkg::CH_BS:
                                begin
                                    if (ccol_reg != '0)
                                    begin
                                        ccol_next = ccol_reg - 1'b1;
                                    end
                                end
                                tcw_pkg::CH_TAB:
                                begin
                                    ccol_next = tab_col[ccol_reg];
                                    adv       = tab_wrap[ccol_reg];
                                end
                                default:
                                begin
                                    if (last_col)
                                    begin
                                        ccol_next = '0;
                                        adv       = 1'b1;
                                    end
                                    else
                                    begin
                                        ccol_next = ccol_reg + 1'b1;
                                    end
                                end
                            endcase
                            if (adv)
                            begin
                                if (last_row)
                                begin
                                    state_next = tcw_pkg::ST_SCROLL_MOVE;
                                end
                                else
                                begin
                                    crow_next = crow_reg + 1'b1;
                                end
                            end
                        end
                        tcw_pkg::OP_SET:
                        begin
                            if (in_range)
                            begin
                                crow_next = ROW_W'(row);
                                ccol_next = COL_W'(column);
                            end
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            state_next = tcw_pkg::ST_CLEAR;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            rd_ok_next = in_range;
                            state_next = tcw_pkg::ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ:
            begin
                if (rd_ok_reg)
                begin
                    rchar_next  = mem_rdata[tcw_pkg::CHAR_W-1:0];
                    rcolor_next = mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                end
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SCROLL_MOVE:
            begin
                // phase 0 reads one line down, phase 1 writes it back
                phase_next = ~phase_reg;
                if (phase_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == ADDR_W'(MOVE_CELLS - 1))
                    begin
                        state_next = tcw_pkg::ST_SCROLL_BLANK;
                    end
                end
            end
            tcw_pkg::ST_SCROLL_BLANK:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // memory and handshake outputs
    always_comb
    begin
        mem_cmd   = '0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        mem_raddr = cnt_reg + ADDR_W'(COLS);
        in_stall  = (state_reg != tcw_pkg::ST_IDLE);
        res_valid = (state_reg == tcw_pkg::ST_DONE);
        unique case (state_reg) inside
            tcw_pkg::ST_INIT:
            begin
                mem_cmd.wr_en = 1'b1;
            end
            tcw_pkg::ST_IDLE:
            begin
                mem_raddr = in_addr;
                mem_waddr = cur_addr;
                mem_wdata = {color, char_code};
                if (accept && (tcw_pkg::op_t'(op) == tcw_pkg::OP_READ))
                begin
                    mem_cmd.rd_en = 1'b1;
                end
                if (accept && (tcw_pkg::op_t'(op) == tcw_pkg::OP_PUT))
                begin
                    case (char_code) inside
                        tcw_pkg::CH_NUL, tcw_pkg::CH_NL, tcw_pkg::CH_CR,
                        tcw_pkg::CH_BS, tcw_pkg::CH_TAB:
                        begin
                        end
                        default:
                        begin
                            mem_cmd.wr_en = 1'b1;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_SCROLL_MOVE:
            begin
                mem_cmd.rd_en = ~phase_reg;
                mem_cmd.wr_en = phase_reg;
                mem_wdata     = mem_rdata;
            end
            tcw_pkg::ST_SCROLL_BLANK:
            begin
                mem_cmd.wr_en = 1'b1;
                mem_wdata     = {{tcw_pkg::CHAR_W{1'b0}}, tcw_pkg::CH_SPACE};
            end
            tcw_pkg::ST_CLEAR:
            begin
                mem_cmd.wr_en = 1'b1;
                mem_wdata     = {color, tcw_pkg::CH_SPACE};
            end
            tcw_pkg::ST_READ, tcw_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign res_pos   = tcw_pkg::POS_W'(cur_addr);
    assign res_char  = rchar_reg;
    assign res_color = rcolor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
            crow_reg  <= '0;
            ccol_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            crow_reg  <= crow_next;
            ccol_reg  <= ccol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ok_reg  <= rd_ok_next;
        rchar_reg  <= rchar_next;
        rcolor_reg <= rcolor_next;
    end

endmodule

// ===== hw/rtl/text_console_char_writer.sv =====
// text console char writer: top level with color register and result buffer
// sequencing: put char and set cursor go from idle to done, read cell passes a read state,
// clear writes every cell, a put char that scrolls moves the lines up (one read and one write
// per cell) and blanks the last line; throughput: one item at a time
// reset: cursor and color to 0; the cell store is zeroed by a pass over all cells
// after reset, during which in_stall stays high
module text_console_char_writer #(
    parameter int COLS     = tcw_pkg::DEF_COLS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]   text_color,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcw_pkg::ROW_IN_W-1:0] row,
    input  logic [tcw_pkg::COL_IN_W-1:0] column,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tcw_pkg::POS_W-1:0]    cursor_pos,
    output logic [tcw_pkg::CHAR_W-1:0]   cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]   cell_color
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [tcw_pkg::CHAR_W-1:0] color_reg, color_next;
    logic                       out_valid_reg, out_valid_next;
    logic [tcw_pkg::POS_W-1:0]  pos_reg;
    logic [tcw_pkg::CHAR_W-1:0] char_reg;
    logic [tcw_pkg::CHAR_W-1:0] ccolor_reg;

    logic                       res_ready;
    logic                       res_valid;
    logic                       res_load;
    logic [tcw_pkg::POS_W-1:0]  res_pos;
    logic [tcw_pkg::CHAR_W-1:0] res_char;
    logic [tcw_pkg::CHAR_W-1:0] res_color;

    tcw_pkg::mem_cmd_t          mem_cmd;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;

    assign cfg_ready  = 1'b1;
    assign color_next = cfg_valid ? text_color : color_reg;

    // result buffer frees the sequencer while a beat waits downstream
    assign res_ready      = !out_valid_reg || !out_stall;
    assign res_load       = res_valid && res_ready;
    assign out_valid_next = res_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            pos_reg    <= res_pos;
            char_reg   <= res_char;
            ccolor_reg <= res_color;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_pos = pos_reg;
    assign cell_char  = char_reg;
    assign cell_color = ccolor_reg;

    tcw_ctrl #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .char_code (char_code),
        .row       (row),
        .column    (column),
        .color     (color_reg),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_pos   (res_pos),
        .res_char  (res_char),
        .res_color (res_color),
        .mem_cmd   (mem_cmd),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .cmd   (mem_cmd),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
